// ===== sv/ssrk_pkg.sv =====
// Package for the sequence store with range k-th select.
// Command codes, status codes and shared types; no dependencies.
package ssrk_pkg;
  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_DELETE  = 2'd1;
  localparam logic [1:0] FUNC_REVERSE = 2'd2;
  localparam logic [1:0] FUNC_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic [VAL_W-1:0] kth_value;
    logic [1:0]       status;
  } ssrk_res_t;
endpackage

// ===== sv/ssrk_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module ssrk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== sv/sequence_store_range_kth_select_unit.sv =====
// An out-of-bounds command or an insert into a full store goes straight to the result;
// insert shifts entries up from the end, delete shifts them down, reverse swaps pairs
// from both ends inward and query counts, for each candidate in the range, the entries
// below and equal to it (one RAM access and one shared signed compare per cycle). One item
// at a time: s_axis_tready returns the cycle after the result is taken. Reset (rst_ni low,
// asynchronous) empties the store; RAM is not cleared. Depends on ssrk_pkg and ssrk_ram.
module sequence_store_range_kth_select_unit #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[1:0], pos_first[12:2], pos_last[23:13], value[55:24], rank[66:56]
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], kth_value[33:2], length[44:34]
  output logic [47:0] m_axis_tdata
);
  import ssrk_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = ($clog2(DEPTH + 1) > POS_W) ? $clog2(DEPTH + 1) + 1
                                                            : POS_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SHR   = 4'd2;  // read a-1 for insert
  localparam logic [3:0] S_SHW   = 4'd3;  // write a
  localparam logic [3:0] S_DLR   = 4'd4;  // read a for delete
  localparam logic [3:0] S_DLW   = 4'd5;  // write a-1
  localparam logic [3:0] S_RVA   = 4'd6;  // read a
  localparam logic [3:0] S_RVB   = 4'd7;  // read b, hold a
  localparam logic [3:0] S_RVW1  = 4'd8;  // write a <= b
  localparam logic [3:0] S_RVW2  = 4'd9;  // write b <= a
  localparam logic [3:0] S_QC    = 4'd10; // read candidate
  localparam logic [3:0] S_QCL   = 4'd11; // latch candidate
  localparam logic [3:0] S_QS    = 4'd12; // scan compare
  localparam logic [3:0] S_QD    = 4'd13; // decide
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [1:0]        func_q;
  logic [CW-1:0]     lo_q, hi_q, k_q, a_q, a_d, b_q, b_d, idx_q, idx_d;
  logic [CW-1:0]     below_q, below_d, same_q, same_d;
  logic [VAL_W-1:0]  val_q, tmp_q, tmp_d, cand_q, cand_d;
  logic              out_v_q;
  ssrk_res_t         res_q, res_d;
  logic              ram_we;
  logic [CW-1:0]     ram_pos;
  logic [VAL_W-1:0]  ram_wd, ram_rd;
  logic              lt, eq;

  ssrk_ram #(.Width(VAL_W), .Depth(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_pos[AW-1:0]),
    .wdata_i(ram_wd),
    .rdata_o(ram_rd)
  );

  assign lt = $signed(ram_rd) < $signed(cand_q);
  assign eq = ram_rd == cand_q;

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'd0, count_q[POS_W-1:0], res_q.kth_value, res_q.status};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    a_d = a_q; b_d = b_q; idx_d = idx_q;
    below_d = below_q; same_d = same_q;
    tmp_d = tmp_q; cand_d = cand_q;
    res_d = res_q;
    ram_we = 1'b0; ram_pos = a_q; ram_wd = tmp_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) state_d = S_CHECK;
      end
      S_CHECK: begin
        res_d.status    = ST_OK;
        res_d.kth_value = '0;
        state_d = S_DONE;
        case (func_q)
          FUNC_INSERT: begin
            if (lo_q < 1 || lo_q > count_q + 1) res_d.status = ST_BOUNDS;
            else if (count_q >= CW'(DEPTH)) res_d.status = ST_FULL;
            else begin a_d = count_q; state_d = S_SHR; end
          end
          FUNC_DELETE: begin
            if (lo_q < 1 || lo_q > count_q) res_d.status = ST_BOUNDS;
            else begin a_d = lo_q; state_d = S_DLR; end
          end
          FUNC_REVERSE: begin
            if (lo_q < 1 || lo_q > hi_q || hi_q > count_q) res_d.status = ST_BOUNDS;
            else begin a_d = lo_q - 1; b_d = hi_q - 1; state_d = S_RVA; end
          end
          default: begin
            if (lo_q < 1 || lo_q > hi_q || hi_q > count_q || k_q < 1 ||
                k_q > hi_q - lo_q + 1) res_d.status = ST_BOUNDS;
            else begin a_d = lo_q - 1; state_d = S_QC; end
          end
        endcase
      end
      S_SHR: begin
        if (a_q < lo_q) begin
          ram_we = 1'b1; ram_pos = lo_q - 1; ram_wd = val_q;
          count_d = count_q + 1; state_d = S_DONE;
        end else begin
          ram_pos = a_q - 1; state_d = S_SHW;
        end
      end
      S_SHW: begin
        ram_we = 1'b1; ram_pos = a_q; ram_wd = ram_rd;
        a_d = a_q - 1; state_d = S_SHR;
      end
      S_DLR: begin
        if (a_q >= count_q) begin
          count_d = count_q - 1; state_d = S_DONE;
        end else begin
          ram_pos = a_q; state_d = S_DLW;
        end
      end
      S_DLW: begin
        ram_we = 1'b1; ram_pos = a_q - 1; ram_wd = ram_rd;
        a_d = a_q + 1; state_d = S_DLR;
      end
      S_RVA: begin
        if (a_q >= b_q) state_d = S_DONE;
        else begin ram_pos = a_q; state_d = S_RVB; end
      end
      S_RVB: begin
        tmp_d = ram_rd; ram_pos = b_q; state_d = S_RVW1;
      end
      S_RVW1: begin
        ram_we = 1'b1; ram_pos = a_q; ram_wd = ram_rd; state_d = S_RVW2;
      end
      S_RVW2: begin
        ram_we = 1'b1; ram_pos = b_q; ram_wd = tmp_q;
        a_d = a_q + 1; b_d = b_q - 1; state_d = S_RVA;
      end
      S_QC: begin
        ram_pos = a_q; state_d = S_QCL;
      end
      S_QCL: begin
        cand_d = ram_rd; below_d = '0; same_d = '0;
        idx_d = lo_q - 1; ram_pos = lo_q - 1; state_d = S_QS;
      end
      S_QS: begin
        // ram_rd holds entry idx_q
        if (lt) below_d = below_q + 1;
        else if (eq) same_d = same_q + 1;
        if (idx_q + 1 >= hi_q) state_d = S_QD;
        else begin idx_d = idx_q + 1; ram_pos = idx_q + 1; end
      end
      S_QD: begin
        if (below_q < k_q && k_q <= below_q + same_q) begin
          res_d.kth_value = cand_q; state_d = S_DONE;
        end else if (a_q + 1 >= hi_q) state_d = S_DONE;
        else begin a_d = a_q + 1; state_d = S_QC; end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_DONE) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; idx_q <= idx_d;
    below_q <= below_d; same_q <= same_d;
    tmp_q <= tmp_d; cand_q <= cand_d; res_q <= res_d;
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tdata[1:0];
      lo_q   <= CW'(s_axis_tdata[12:2]);
      hi_q   <= CW'(s_axis_tdata[23:13]);
      val_q  <= s_axis_tdata[55:24];
      k_q    <= CW'(s_axis_tdata[66:56]);
    end
  end

  logic unused_pad;
  assign unused_pad = ^s_axis_tdata[71:67];
endmodule

// ===== sv/ssrk_checker.sv =====
// Port-level checker for the sequence store unit, bound to the top level.
// Depends on ssrk_pkg.
module ssrk_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import ssrk_pkg::*;

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_accept_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accepted while result pending");
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] <= ST_FULL)
    else $error("bad status");
  a_kth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == '0)
    else $error("kth nonzero on error");
endmodule

bind sequence_store_range_kth_select_unit ssrk_checker u_ssrk_checker (.*);

// ===== tb/sv/sequence_store_range_kth_select_unit_test.sv =====
// Testbench for sequence_store_range_kth_select_unit: directed and random commands
// checked against a behavioral model of the ordered store. Depends on ssrk_pkg.
`timescale 1ns / 1ps
module sequence_store_range_kth_select_unit_test;
  import ssrk_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] kth_value;
    logic [10:0] length;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  sequence_store_range_kth_select_unit #(.DEPTH(DEPTH)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  logic signed [31:0] store_vals[DEPTH];
  int unsigned        store_len;
  result_t            pending[$];
  bit                 failed;
  int                 hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [31:0] kth_smallest(int lo, int hi, int k);
    int below;
    int same;
    logic signed [31:0] cand;
    for (int a = lo; a <= hi; a++) begin
      cand = store_vals[a-1];
      below = 0;
      same = 0;
      for (int b = lo; b <= hi; b++) begin
        if (store_vals[b-1] < cand) below++;
        else if (store_vals[b-1] == cand) same++;
      end
      if (below < k && k <= below + same) return cand;
    end
    return '0;
  endfunction

  function automatic result_t apply_command(logic [1:0] func, int lo, int hi,
                                            logic signed [31:0] val, int k);
    result_t r;
    logic signed [31:0] t;
    int ia;
    int ib;
    r = '0;
    r.status = ST_OK;
    case (func)
      FUNC_INSERT: begin
        if (lo < 1 || lo > store_len + 1) r.status = ST_BOUNDS;
        else if (store_len >= DEPTH) r.status = ST_FULL;
        else begin
          for (int a = store_len; a >= lo; a--) store_vals[a] = store_vals[a-1];
          store_vals[lo-1] = val;
          store_len++;
        end
      end
      FUNC_DELETE: begin
        if (lo < 1 || lo > store_len) r.status = ST_BOUNDS;
        else begin
          for (int a = lo; a < store_len; a++) store_vals[a-1] = store_vals[a];
          store_len--;
        end
      end
      FUNC_REVERSE: begin
        if (lo < 1 || lo > hi || hi > store_len) r.status = ST_BOUNDS;
        else begin
          ia = lo - 1;
          ib = hi - 1;
          while (ia < ib) begin
            t = store_vals[ia];
            store_vals[ia] = store_vals[ib];
            store_vals[ib] = t;
            ia++;
            ib--;
          end
        end
      end
      default: begin
        if (lo < 1 || lo > hi || hi > store_len || k < 1 || k > hi - lo + 1)
          r.status = ST_BOUNDS;
        else r.kth_value = kth_smallest(lo, hi, k);
      end
    endcase
    r.length = store_len[10:0];
    return r;
  endfunction

  task automatic send_item(logic [1:0] func, int lo, int hi, logic signed [31:0] val,
                           int k, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    lo = lo & 32'h7ff;
    hi = hi & 32'h7ff;
    k = k & 32'h7ff;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, k[10:0], val, hi[10:0], lo[10:0], func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending.push_back(apply_command(func, lo, hi, val, k));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin : result_checker
    result_t got;
    result_t want;
    int stall;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = '0;
      got.status = m_axis_tdata[1:0];
      got.kth_value = m_axis_tdata[33:2];
      got.length = m_axis_tdata[44:34];
      if (pending.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        failed = 1;
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) begin
          $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
          failed = 1;
        end
        if (got.kth_value !== want.kth_value) begin
          $display("%0t kth_value: expected %h actual %h", $time, want.kth_value,
                   got.kth_value);
          failed = 1;
        end
        if (got.length !== want.length) begin
          $display("%0t length: expected %0d actual %0d", $time, want.length, got.length);
          failed = 1;
        end
      end
    end
  end

  task automatic test_edges();
    send_item(FUNC_DELETE, 1, 1, 0, 1);
    send_item(FUNC_QUERY, 1, 1, 0, 1);
    send_item(FUNC_REVERSE, 1, 1, 0, 1);
    send_item(FUNC_INSERT, 2, 1, 5, 1);
    send_item(FUNC_INSERT, 0, 0, 5, 0);
    send_item(FUNC_INSERT, 1, 1, 32'sh7fffffff, 1);
    send_item(FUNC_INSERT, 1, 1, 32'sh80000000, 1);
    send_item(FUNC_INSERT, 3, 1, -1, 1);
    send_item(FUNC_INSERT, 2, 1, 0, 1);
    send_item(FUNC_INSERT, 5, 1, 0, 1);
    send_item(FUNC_QUERY, 1, 5, 0, 1);
    send_item(FUNC_QUERY, 1, 5, 0, 5);
    send_item(FUNC_QUERY, 1, 5, 0, 3);
    send_item(FUNC_QUERY, 2, 2, 0, 1);
    send_item(FUNC_QUERY, 1, 5, 0, 6);
    send_item(FUNC_QUERY, 1, 5, 0, 0);
    send_item(FUNC_QUERY, 3, 2, 0, 1);
    send_item(FUNC_QUERY, 1, 6, 0, 1);
    send_item(FUNC_REVERSE, 1, 5, 0, 2047);
    send_item(FUNC_REVERSE, 3, 3, 0, 1);
    send_item(FUNC_QUERY, 1, 4, 0, 2);
    send_item(FUNC_DELETE, 5, 2047, 0, 2047);
    send_item(FUNC_DELETE, 6, 1, 0, 1);
    send_item(FUNC_DELETE, 2047, 1, 32'shffffffff, 1);
    send_item(FUNC_QUERY, 2047, 2047, 0, 2047);
  endtask

  task automatic test_random(int n);
    int len;
    int lo;
    int hi;
    int kind;
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      len = store_len;
      kind = $urandom_range(0, 9);
      v = $urandom();
      if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 3);
      if (kind == 0) begin
        send_item(2'($urandom_range(0, 3)), $urandom_range(0, 2047),
                  $urandom_range(0, 2047), v, $urandom_range(0, 2047));
      end else if (kind <= 3 || len < 2) begin
        send_item(FUNC_INSERT, $urandom_range(1, len + 1), $urandom(), v, $urandom());
      end else if (kind == 4) begin
        send_item(FUNC_DELETE, $urandom_range(1, len), $urandom(), v, $urandom());
      end else begin
        lo = $urandom_range(1, len);
        hi = $urandom_range(lo, (lo + 12 > len) ? len : lo + 12);
        if (kind <= 6) send_item(FUNC_REVERSE, lo, hi, v, $urandom());
        else send_item(FUNC_QUERY, lo, hi, v, $urandom_range(1, hi - lo + 1));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 6; i++)
      send_item(FUNC_QUERY, 1, 2, 0, 1, 1);
    wait_drained();
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    store_len = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_backpressure();
    test_random(110);
    wait_drained();
    repeat (4000) @(posedge clk_i);
    if (!failed && pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
